FILE: rtl/tflm_pkg.sv
// tflm_pkg: item types, command codes and shared constants of the trie matcher
// depends on nothing; used by trie_failure_link_matcher, tflm_checker and trie_failure_link_matcher_tb
`default_nettype none

package tflm_pkg;

   // default table depths
   localparam int DEF_NODE_COUNT = 65536;
   localparam int DEF_EDGE_COUNT = 65536;

   // maximal numbers at or above this are a walk error
   localparam int MAXIMAL_COUNT = 16384;

   // width that holds every field value and every table bound
   localparam int CMP_W = 21;

   // saturation value of the letter position
   localparam logic [23:0] POS_MAX = 24'hFFFFFF;

   // command codes
   localparam logic [1:0] CMD_WRITE_NODE = 2'd0;
   localparam logic [1:0] CMD_WRITE_EDGE = 2'd1;
   localparam logic [1:0] CMD_SCAN       = 2'd2;
   localparam logic [1:0] CMD_RESTART    = 2'd3;

   // input item
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] table_index;
      logic [16:0] edge_first;
      logic [16:0] edge_end;
      logic [16:0] rewind_target;
      logic        node_is_maximal;
      logic [13:0] maximal_number;
      logic [7:0]  edge_letter;
      logic [15:0] edge_target;
      logic [7:0]  letter;
   } tflm_req_type;

   // result item
   typedef struct packed {
      logic        hit;
      logic [13:0] hit_number;
      logic [23:0] letter_position;
      logic        first_hit;
      logic        walk_error;
   } tflm_rsp_type;

   // one node table entry
   typedef struct packed {
      logic [16:0] edge_first;
      logic [16:0] edge_end;
      logic [16:0] rewind;
      logic        maximal;
      logic [13:0] number;
   } node_entry_type;

   // one edge table entry
   typedef struct packed {
      logic [7:0]  label;
      logic [15:0] child;
   } edge_entry_type;

endpackage

`default_nettype wire

FILE: rtl/trie_failure_link_matcher.sv
// trie_failure_link_matcher: trie automaton with failure links over node and edge memories
// depends on tflm_pkg (item types, command codes, constants)
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_data (tflm_req_type)
//   rsp       out         rsp_valid / rsp_ready   rsp_data (tflm_rsp_type)
//
// node writes, edge writes and restarts give no result
// a scan reads the current node, then examines its child edges in turn and follows
// rewind links until a label matches, then reads the child node; a bad edge, child or
// rewind link ends it with a walk error; every step is one read of a node or edge memory
// reset is synchronous; tables are not cleared, unwritten entries read as garbage
// a finished result sits in the output register while the next item is taken;
// a scan that finishes while that register is still full waits for rsp_ready
`default_nettype none

module trie_failure_link_matcher
   import tflm_pkg::*;
#(
   parameter int NODE_COUNT = DEF_NODE_COUNT,
   parameter int EDGE_COUNT = DEF_EDGE_COUNT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire tflm_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output tflm_rsp_type      rsp_data
);

   localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EDGE_AW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
   localparam int RCNT_W  = $clog2(NODE_COUNT + 1);

   localparam logic [CMP_W-1:0] NODE_LIM = CMP_W'(NODE_COUNT);
   localparam logic [CMP_W-1:0] EDGE_LIM = CMP_W'(EDGE_COUNT);
   localparam logic [CMP_W-1:0] MAX_LIM  = CMP_W'(MAXIMAL_COUNT);

   // state codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NODE = 2'd1;
   localparam logic [1:0] S_EDGE = 2'd2;
   localparam logic [1:0] S_LEAF = 2'd3;

   // tables
   node_entry_type node_mem [NODE_COUNT];
   edge_entry_type edge_mem [EDGE_COUNT];

   // control registers
   logic [1:0]        state_ff, state_in;
   logic [15:0]       cur_ff, cur_in;
   logic [23:0]       pos_ff, pos_in;
   logic              seen_ff, seen_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // walk registers
   logic [7:0]        letter_ff, letter_in;
   logic [16:0]       edge_idx_ff, edge_idx_in;
   logic [16:0]       edge_lim_ff, edge_lim_in;
   logic [16:0]       rew_ff, rew_in;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic [15:0]       next_node_ff, next_node_in;
   tflm_rsp_type      rsp_ff, rsp_in;

   // memory ports
   logic               node_wr, node_rd;
   logic [NODE_AW-1:0] node_waddr, node_raddr;
   node_entry_type     node_wdata;
   node_entry_type     node_rdata_ff;
   logic               edge_wr, edge_rd;
   logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
   edge_entry_type     edge_wdata;
   edge_entry_type     edge_rdata_ff;

   // walk decision signals
   logic        out_free;
   logic [16:0] cand_i, cand_lim, cand_rew;
   logic        step_edge, advance_err, do_advance;
   logic        child_bad;
   logic        fin, fin_err, fin_hit;
   logic [13:0] fin_num;
   logic [15:0] fin_node;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // write data and addresses straight from the item
   assign node_waddr = NODE_AW'(CMP_W'(req_data.table_index));
   assign edge_waddr = EDGE_AW'(CMP_W'(req_data.table_index));
   assign node_wdata = '{edge_first: req_data.edge_first,
                         edge_end:   req_data.edge_end,
                         rewind:     req_data.rewind_target,
                         maximal:    req_data.node_is_maximal,
                         number:     req_data.maximal_number};
   assign edge_wdata = '{label: req_data.edge_letter, child: req_data.edge_target};

   // next edge candidate: first child after a node read, else the one after the last
   always_comb begin
      if (state_ff == S_NODE) begin
         cand_i   = node_rdata_ff.edge_first;
         cand_lim = node_rdata_ff.edge_end;
         cand_rew = node_rdata_ff.rewind;
      end else begin
         cand_i   = edge_idx_ff + 17'd1;
         cand_lim = edge_lim_ff;
         cand_rew = rew_ff;
      end
      step_edge = (cand_i < cand_lim);
      if (step_edge) begin
         advance_err = (CMP_W'(cand_i) >= EDGE_LIM);
      end else begin
         advance_err = (rcnt_ff >= RCNT_W'(NODE_COUNT)) || (CMP_W'(cand_rew) >= NODE_LIM);
      end
      child_bad = (CMP_W'(edge_rdata_ff.child) >= NODE_LIM) || (edge_rdata_ff.child == 16'd0);
   end

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      letter_in    = letter_ff;
      edge_idx_in  = edge_idx_ff;
      edge_lim_in  = edge_lim_ff;
      rew_in       = rew_ff;
      rcnt_in      = rcnt_ff;
      next_node_in = next_node_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      node_wr      = 1'b0;
      edge_wr      = 1'b0;
      node_rd      = 1'b0;
      edge_rd      = 1'b0;
      node_raddr   = NODE_AW'(CMP_W'(cur_ff));
      edge_raddr   = EDGE_AW'(CMP_W'(cand_i));
      do_advance   = 1'b0;
      fin          = 1'b0;
      fin_err      = 1'b0;
      fin_hit      = 1'b0;
      fin_num      = 14'd0;
      fin_node     = next_node_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  CMD_WRITE_NODE: begin
                     node_wr = (CMP_W'(req_data.table_index) < NODE_LIM);
                  end
                  CMD_WRITE_EDGE: begin
                     edge_wr = (CMP_W'(req_data.table_index) < EDGE_LIM);
                  end
                  CMD_SCAN: begin
                     node_rd   = 1'b1;
                     letter_in = req_data.letter;
                     rcnt_in   = '0;
                     state_in  = S_NODE;
                  end
                  CMD_RESTART: begin
                     cur_in  = 16'd0;
                     pos_in  = 24'd0;
                     seen_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_NODE: begin
            do_advance = 1'b1;
         end
         S_EDGE: begin
            if (edge_rdata_ff.label == letter_ff) begin
               if (child_bad) begin
                  fin     = 1'b1;
                  fin_err = 1'b1;
               end else begin
                  // read the child to learn whether it is maximal
                  node_rd      = 1'b1;
                  node_raddr   = NODE_AW'(CMP_W'(edge_rdata_ff.child));
                  next_node_in = edge_rdata_ff.child;
                  state_in     = S_LEAF;
               end
            end else begin
               do_advance = 1'b1;
            end
         end
         S_LEAF: begin
            fin = 1'b1;
            if (node_rdata_ff.maximal) begin
               if (CMP_W'(node_rdata_ff.number) >= MAX_LIM) begin
                  fin_err = 1'b1;
               end else begin
                  fin_hit = 1'b1;
                  fin_num = node_rdata_ff.number;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // try the next child edge, or follow the rewind link
      if (do_advance) begin
         if (advance_err) begin
            fin     = 1'b1;
            fin_err = 1'b1;
         end else if (step_edge) begin
            edge_rd     = 1'b1;
            edge_idx_in = cand_i;
            edge_lim_in = cand_lim;
            rew_in      = cand_rew;
            state_in    = S_EDGE;
         end else begin
            node_rd    = 1'b1;
            node_raddr = NODE_AW'(CMP_W'(cand_rew));
            rcnt_in    = rcnt_ff + RCNT_W'(1);
            state_in   = S_NODE;
         end
      end

      // deliver the result; hold the state while the output register is full
      if (fin) begin
         if (out_free) begin
            rsp_valid_in           = 1'b1;
            rsp_in.hit             = fin_hit;
            rsp_in.hit_number      = fin_num;
            rsp_in.letter_position = pos_ff;
            rsp_in.first_hit       = fin_hit && !seen_ff;
            rsp_in.walk_error      = fin_err;
            cur_in                 = fin_err ? 16'd0 : fin_node;
            seen_in                = seen_ff || fin_hit;
            pos_in                 = (pos_ff != POS_MAX) ? pos_ff + 24'd1 : pos_ff;
            state_in               = S_IDLE;
         end else begin
            state_in = state_ff;
         end
      end
   end

   // node memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (node_wr) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_rd) begin
         node_rdata_ff <= node_mem[node_raddr];
      end
   end

   // edge memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (edge_wr) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (edge_rd) begin
         edge_rdata_ff <= edge_mem[edge_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= 16'd0;
         pos_ff       <= 24'd0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and result registers
   always_ff @(posedge clock) begin
      letter_ff    <= letter_in;
      edge_idx_ff  <= edge_idx_in;
      edge_lim_ff  <= edge_lim_in;
      rew_ff       <= rew_in;
      rcnt_ff      <= rcnt_in;
      next_node_ff <= next_node_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: rtl/tflm_checker.sv
// tflm_checker: port-level assertions for the trie matcher, bound to its top level
// depends on tflm_pkg and trie_failure_link_matcher
`default_nettype none

module tflm_checker
   import tflm_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire tflm_req_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire tflm_rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a failed walk reports no hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.walk_error |-> !rsp_data.hit)
      else $error("walk error together with a hit");

   // without a hit, number and first flag stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.hit_number == 14'd0 && !rsp_data.first_hit)
      else $error("hit fields set without a hit");

   // writes and restarts never produce a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd != CMD_SCAN && !rsp_valid |=> !rsp_valid)
      else $error("result item after a non-scan item");

endmodule

bind trie_failure_link_matcher tflm_checker u_tflm_checker (.*);

`default_nettype wire

FILE: sim/trie_failure_link_matcher_tb.sv
// trie_failure_link_matcher_tb: randomized self-checking bench for the trie matcher
// depends on tflm_pkg and trie_failure_link_matcher; scan results are predicted
// from a local copy of the node and edge tables and compared in order
module trie_failure_link_matcher_tb;
   import tflm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // nodes and edges that are always written: a low and a high block of each
   localparam int unsigned NODE_BLOCK    = 16;
   localparam int unsigned EDGE_BLOCK    = 32;
   localparam int unsigned NODE_TOP      = DEF_NODE_COUNT;
   localparam int unsigned EDGE_TOP      = DEF_EDGE_COUNT;
   localparam logic [16:0] REWIND_NONE   = 17'h10000;
   localparam int unsigned MAX_NUMBER    = MAXIMAL_COUNT - 1;
   localparam logic [7:0]  ALPHA_BASE    = 8'h61;
   localparam int unsigned ALPHA_SIZE    = 4;
   localparam logic [7:0]  LETTER_A      = ALPHA_BASE;
   localparam logic [7:0]  LETTER_B      = ALPHA_BASE + 8'd1;
   localparam int unsigned RANDOM_ITEMS  = 930;
   localparam int unsigned HOLD_AFTER    = 150;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned STALL_LIMIT   = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   tflm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   tflm_rsp_type rsp_data;

   trie_failure_link_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow of the automaton
   node_entry_type node_mem [NODE_TOP];
   edge_entry_type edge_mem [EDGE_TOP];
   logic [15:0]    cur_node = '0;
   logic [23:0]    pos_count = '0;
   logic           seen_hit = 1'b0;

   tflm_req_type   cmd_queue [$];
   tflm_rsp_type   expected_scan_results [$];

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned n_node_writes = 0, n_edge_writes = 0, n_scans = 0, n_restarts = 0;
   int unsigned n_hits = 0, n_first_hits = 0, n_walk_errors = 0;
   logic        req_taken = 1'b0;
   int unsigned send_idle = 0;
   int unsigned rsp_run = 0;
   int unsigned rsp_gap = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned stall_cycles = 0;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // pool index to table index
   function automatic logic [15:0] node_at(input int unsigned k);
      return (k < NODE_BLOCK) ? 16'(k) : 16'(NODE_TOP - 2 * NODE_BLOCK + k);
   endfunction

   function automatic logic [15:0] edge_at(input int unsigned j);
      return (j < EDGE_BLOCK) ? 16'(j) : 16'(EDGE_TOP - 2 * EDGE_BLOCK + j);
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap(input logic calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
      return ALPHA_BASE + 8'($urandom_range(0, ALPHA_SIZE - 1));
   endfunction

   // fields that the command ignores carry random bits
   function automatic tflm_req_type random_payload(input logic [1:0] cmd);
      logic [127:0] bits;
      tflm_req_type it;
      bits = {$urandom, $urandom, $urandom, $urandom};
      it = bits[$bits(tflm_req_type)-1:0];
      it.cmd = cmd;
      return it;
   endfunction

   function automatic tflm_req_type node_item(input logic [15:0] idx,
         input logic [16:0] first, input logic [16:0] stop, input logic [16:0] rewind,
         input logic maximal, input logic [13:0] number);
      tflm_req_type it;
      it = random_payload(CMD_WRITE_NODE);
      it.table_index = idx;
      it.edge_first = first;
      it.edge_end = stop;
      it.rewind_target = rewind;
      it.node_is_maximal = maximal;
      it.maximal_number = number;
      return it;
   endfunction

   function automatic tflm_req_type edge_item(input logic [15:0] idx,
         input logic [7:0] label, input logic [15:0] child);
      tflm_req_type it;
      it = random_payload(CMD_WRITE_EDGE);
      it.table_index = idx;
      it.edge_letter = label;
      it.edge_target = child;
      return it;
   endfunction

   function automatic tflm_req_type scan_item(input logic [7:0] ch);
      tflm_req_type it;
      it = random_payload(CMD_SCAN);
      it.letter = ch;
      return it;
   endfunction

   // pool node k: rewinds only to a lower pool node or nowhere, so no loops;
   // child ranges stay inside the written edge blocks unless empty or reversed
   function automatic tflm_req_type make_node_write(input int unsigned k);
      int unsigned first;
      int unsigned stop;
      int unsigned pick;
      logic [16:0] rewind;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         first = $urandom_range(0, EDGE_BLOCK - 1);
         stop = first + $urandom_range(1, 4);
         if (stop > EDGE_BLOCK) stop = EDGE_BLOCK;
      end else if (pick < 7) begin
         first = EDGE_TOP - EDGE_BLOCK + $urandom_range(0, EDGE_BLOCK - 1);
         stop = first + $urandom_range(1, 4);
         if (stop > EDGE_TOP) stop = EDGE_TOP;
      end else if (pick < 8) begin
         first = $urandom_range(0, EDGE_TOP);
         stop = first;
      end else begin
         stop = $urandom_range(0, EDGE_TOP - 1);
         first = $urandom_range(stop + 1, EDGE_TOP);
      end
      if (k == 0 || $urandom_range(0, 4) == 0) rewind = REWIND_NONE;
      else rewind = {1'b0, node_at($urandom_range(0, k - 1))};
      return node_item(node_at(k), 17'(first), 17'(stop), rewind,
                       $urandom_range(0, 2) == 0, 14'($urandom_range(0, MAX_NUMBER)));
   endfunction

   // pool edge j: child is a pool node, now and then the root
   function automatic tflm_req_type make_edge_write(input int unsigned j);
      logic [15:0] child;
      if ($urandom_range(0, 14) == 0) child = '0;
      else child = node_at($urandom_range(1, 2 * NODE_BLOCK - 1));
      return edge_item(edge_at(j), pick_letter(), child);
   endfunction

   // one letter through the automaton; updates the shadow state
   function automatic tflm_rsp_type scan_letter(input logic [7:0] ch);
      int unsigned at;
      int unsigned idx;
      int unsigned rewinds;
      int          reached;
      logic        done;
      tflm_rsp_type r;
      at = cur_node;
      rewinds = 0;
      reached = -1;
      done = 1'b0;
      while (!done) begin
         if (at >= NODE_TOP) begin
            done = 1'b1;
         end else begin
            for (idx = node_mem[at].edge_first; idx < node_mem[at].edge_end && !done;
                 idx++) begin
               if (idx >= EDGE_TOP) begin
                  done = 1'b1;
               end else if (edge_mem[idx].label == ch) begin
                  if (edge_mem[idx].child != 0) reached = edge_mem[idx].child;
                  done = 1'b1;
               end
            end
            if (!done) begin
               if (rewinds >= NODE_TOP) begin
                  done = 1'b1;
               end else begin
                  rewinds++;
                  at = node_mem[at].rewind;
               end
            end
         end
      end
      r = '0;
      r.letter_position = pos_count;
      if (reached >= 0 && node_mem[reached].maximal) begin
         if (node_mem[reached].number >= MAXIMAL_COUNT) begin
            reached = -1;
         end else begin
            r.hit = 1'b1;
            r.hit_number = node_mem[reached].number;
            r.first_hit = !seen_hit;
            seen_hit = 1'b1;
         end
      end
      if (reached < 0) begin
         r.walk_error = 1'b1;
         cur_node = '0;
      end else begin
         cur_node = 16'(reached);
      end
      if (pos_count != POS_MAX) pos_count++;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // accepted input item: update tables or predict a result
   task automatic apply_item(input tflm_req_type it);
      case (it.cmd)
         CMD_WRITE_NODE: begin
            node_mem[it.table_index] = {it.edge_first, it.edge_end, it.rewind_target,
                                        it.node_is_maximal, it.maximal_number};
            n_node_writes++;
         end
         CMD_WRITE_EDGE: begin
            edge_mem[it.table_index] = {it.edge_letter, it.edge_target};
            n_edge_writes++;
         end
         CMD_SCAN: begin
            expected_scan_results.push_back(scan_letter(it.letter));
            n_scans++;
         end
         default: begin
            cur_node = '0;
            pos_count = '0;
            seen_hit = 1'b0;
            n_restarts++;
         end
      endcase
   endtask

   // accepted result against the oldest prediction
   task automatic check_result(input tflm_rsp_type got);
      tflm_rsp_type want;
      if (expected_scan_results.size() == 0) begin
         report_mismatch($sformatf("result %0h with no scan pending", got));
      end else begin
         want = expected_scan_results.pop_front();
         if (got.hit !== want.hit)
            report_mismatch($sformatf("result %0d hit: got %b want %b",
                                      results_checked, got.hit, want.hit));
         if (got.hit_number !== want.hit_number)
            report_mismatch($sformatf("result %0d hit_number: got %0d want %0d",
                                      results_checked, got.hit_number, want.hit_number));
         if (got.letter_position !== want.letter_position)
            report_mismatch($sformatf("result %0d letter_position: got %0d want %0d",
                                      results_checked, got.letter_position,
                                      want.letter_position));
         if (got.first_hit !== want.first_hit)
            report_mismatch($sformatf("result %0d first_hit: got %b want %b",
                                      results_checked, got.first_hit, want.first_hit));
         if (got.walk_error !== want.walk_error)
            report_mismatch($sformatf("result %0d walk_error: got %b want %b",
                                      results_checked, got.walk_error, want.walk_error));
      end
      n_hits += got.hit;
      n_first_hits += got.first_hit;
      n_walk_errors += got.walk_error;
      results_checked++;
   endtask

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) apply_item(req_data);
      end
   end

   // sender: next item from the queue after a random idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_idle > 0) begin
            req_valid <= 1'b0;
            send_idle--;
         end else if (cmd_queue.size() > 0) begin
            req_data <= cmd_queue.pop_front();
            req_valid <= 1'b1;
            items_sent++;
            send_idle = pick_gap((items_sent / 64) % 5 == 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random ready runs, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_run > 0) begin
         rsp_run--;
      end else if (rsp_ready) begin
         rsp_gap = pick_gap((results_checked / 64) % 5 == 0);
         rsp_ready <= (rsp_gap == 0);
         rsp_run = (rsp_gap == 0) ? $urandom_range(1, 16) : rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_run = $urandom_range(0, 15);
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned k;
      int unsigned pick;
      tflm_req_type it;

      // load every pool node and edge before the first scan
      for (k = 0; k < 2 * NODE_BLOCK; k++) cmd_queue.push_back(make_node_write(k));
      for (k = 0; k < 2 * EDGE_BLOCK; k++) cmd_queue.push_back(make_edge_write(k));

      // walk ends at root, then rewind to nowhere from the root
      cmd_queue.push_back(random_payload(CMD_RESTART));
      cmd_queue.push_back(node_item(16'd0, 17'd0, 17'd1, REWIND_NONE, 1'b0, 14'd0));
      cmd_queue.push_back(edge_item(16'd0, LETTER_A, 16'd0));
      cmd_queue.push_back(scan_item(LETTER_A));
      cmd_queue.push_back(scan_item(8'hFF));
      // top node and top edge, maximal with the largest number; first and repeat hits
      cmd_queue.push_back(node_item(16'hFFFF, 17'hFFFF, 17'h10000, 17'd0, 1'b1, 14'h3FFF));
      cmd_queue.push_back(edge_item(16'hFFFF, LETTER_B, 16'hFFFF));
      cmd_queue.push_back(edge_item(16'd0, LETTER_A, 16'hFFFF));
      cmd_queue.push_back(scan_item(LETTER_A));
      cmd_queue.push_back(scan_item(LETTER_B));
      cmd_queue.push_back(scan_item(LETTER_A));
      cmd_queue.push_back(scan_item(8'h00));
      // restart clears position and first-hit tracking
      cmd_queue.push_back(random_payload(CMD_RESTART));
      cmd_queue.push_back(scan_item(LETTER_A));
      // reversed child range means no children
      cmd_queue.push_back(node_item(16'hFFFF, 17'h10000, 17'd0, 17'd0, 1'b1, 14'd0));
      cmd_queue.push_back(scan_item(LETTER_B));
      cmd_queue.push_back(scan_item(LETTER_A));
      // childless root rewinding to itself: rewinding until the rewind limit gives a walk error
      cmd_queue.push_back(node_item(16'd0, 17'h10000, 17'h10000, 17'd0, 1'b0, 14'd0));
      cmd_queue.push_back(scan_item(LETTER_A));
      // back to well-formed tables
      cmd_queue.push_back(make_node_write(0));
      cmd_queue.push_back(make_node_write(2 * NODE_BLOCK - 1));
      cmd_queue.push_back(make_edge_write(0));
      cmd_queue.push_back(make_edge_write(2 * EDGE_BLOCK - 1));

      // mostly scans over the small alphabet, with table rewrites and noise
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            it = scan_item(pick_letter());
         end else if (pick < 74) begin
            it = make_node_write($urandom_range(0, 2 * NODE_BLOCK - 1));
         end else if (pick < 86) begin
            it = make_edge_write($urandom_range(0, 2 * EDGE_BLOCK - 1));
         end else if (pick < 90) begin
            it = random_payload(CMD_RESTART);
         end else if (pick < 95) begin
            // node outside the pool: written but never reached
            it = random_payload(CMD_WRITE_NODE);
            it.table_index = 16'($urandom_range(NODE_BLOCK, NODE_TOP - NODE_BLOCK - 1));
         end else begin
            it = random_payload(CMD_WRITE_EDGE);
            it.table_index = 16'($urandom_range(EDGE_BLOCK, EDGE_TOP - EDGE_BLOCK - 1));
         end
         cmd_queue.push_back(it);
      end

      // drain
      while (cmd_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_scan_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d items: %0d node writes, %0d edge writes, %0d scans, %0d restarts",
               items_sent, n_node_writes, n_edge_writes, n_scans, n_restarts);
      $display("checked %0d results: %0d hits (%0d first), %0d walk errors, %0d mismatches",
               results_checked, n_hits, n_first_hits, n_walk_errors, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
